// File: rtl/core/clsm_pkg.sv
// shared types, constants and width helpers for the chained stage latency monitor
package clsm_pkg;

    localparam int NUM_STAGES = 4;
    localparam int STAGE_W = 2;
    localparam int STAMP_W = 63;
    localparam int LAT_W = 24;
    localparam int TOTAL_W = 28;
    localparam int STATUS_W = 2;
    localparam int WLEN_W = 5;
    localparam int REQ_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_OFFSETS = 5;
    localparam int OFS_IDX_W = 3;
    localparam int DEF_WINDOW_DEPTH = 16;

    localparam logic [REQ_W-1:0] REQ_CONTROL = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TICK = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LATENCY_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCEPTION_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANNING_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_OFFSET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_OFFSET = 3'd6;

    localparam logic [WLEN_W-1:0] RST_WINDOW_LENGTH = 5'd10;
    localparam logic [TOTAL_W-1:0] RST_LATENCY_LIMIT = 28'd1000000;

    typedef struct packed {
        logic [LAT_W-1:0]   value;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic                 en;
        logic [STAGE_W-1:0]   stage;
        entry_t               entry;
    } wr_req_t;

    typedef struct packed {
        logic [WLEN_W-1:0]                       window_length;
        logic [TOTAL_W-1:0]                      limit;
        logic [NUM_OFFSETS-1:0][LAT_W-1:0]       offsets;
    } cfg_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0][LAT_W-1:0] newest;
        logic [NUM_STAGES-1:0]            missing_mask;
        logic [STATUS_W-1:0]              status;
        logic [TOTAL_W-1:0]               total;
    } result_t;

    function automatic int ptr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic int cnt_w(input int depth);
        return $clog2(depth + 1);
    endfunction

    function automatic int addr_w(input int depth);
        return $clog2(NUM_STAGES * depth);
    endfunction

endpackage

// File: rtl/core/clsm_store.sv
// sample memory with per-stage write pointers and fill counts
module clsm_store
    import clsm_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  wr_req_t                                      wr,
    input  logic [WLEN_W-1:0]                            window_length,
    input  logic [addr_w(WINDOW_DEPTH)-1:0]              rd_addr,
    output entry_t                                       rd_entry,
    output logic [NUM_STAGES-1:0][ptr_w(WINDOW_DEPTH)-1:0] wp,
    output logic [NUM_STAGES-1:0][cnt_w(WINDOW_DEPTH)-1:0] fill
);

    localparam int PW = ptr_w(WINDOW_DEPTH);
    localparam int FW = cnt_w(WINDOW_DEPTH);
    localparam int AW = addr_w(WINDOW_DEPTH);
    localparam int LW = (FW > WLEN_W) ? FW : WLEN_W;
    localparam int MEM_DEPTH = NUM_STAGES * WINDOW_DEPTH;

    entry_t mem [MEM_DEPTH];
    entry_t rd_entry_reg;

    logic [NUM_STAGES-1:0][PW-1:0] wp_reg, wp_next;
    logic [NUM_STAGES-1:0][FW-1:0] fill_reg, fill_next;

    logic [AW-1:0] wr_addr;
    logic [LW-1:0] len_wide;
    logic [FW-1:0] len;
    logic [FW-1:0] cnt;
    logic [PW-1:0] cur_wp;
    logic [FW-1:0] cur_fill;

    assign cur_wp = wp_reg[wr.stage];
    assign cur_fill = fill_reg[wr.stage];
    assign wr_addr = AW'(wr.stage) * AW'(WINDOW_DEPTH) + AW'(cur_wp);

    // window length clamped to the physical depth
    always_comb
    begin
        if (LW'(window_length) > LW'(WINDOW_DEPTH))
        begin
            len_wide = LW'(WINDOW_DEPTH);
        end
        else
        begin
            len_wide = LW'(window_length);
        end
        len = len_wide[FW-1:0];
    end

    always_comb
    begin
        wp_next = wp_reg;
        fill_next = fill_reg;
        cnt = cur_fill;
        if (cur_fill < FW'(WINDOW_DEPTH))
        begin
            cnt = cur_fill + FW'(1);
        end
        if (cnt > len)
        begin
            cnt = len;
        end
        if (wr.en)
        begin
            if (cur_wp == PW'(WINDOW_DEPTH - 1))
            begin
                wp_next[wr.stage] = '0;
            end
            else
            begin
                wp_next[wr.stage] = cur_wp + PW'(1);
            end
            fill_next[wr.stage] = cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;
    assign wp = wp_reg;
    assign fill = fill_reg;

endmodule

// File: rtl/core/clsm_seq.sv
// tick sequencer: newest-value reads, chained window search, offset sum and limit compare
module clsm_seq
    import clsm_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    output logic                                         idle,
    input  logic [NUM_STAGES-1:0][ptr_w(WINDOW_DEPTH)-1:0] wp,
    input  logic [NUM_STAGES-1:0][cnt_w(WINDOW_DEPTH)-1:0] fill,
    output logic [addr_w(WINDOW_DEPTH)-1:0]              rd_addr,
    input  entry_t                                       rd_entry,
    input  cfg_t                                         cfg,
    input  logic                                         res_ready,
    output logic                                         res_valid,
    output result_t                                      result
);

    localparam int PW = ptr_w(WINDOW_DEPTH);
    localparam int FW = cnt_w(WINDOW_DEPTH);
    localparam int AW = addr_w(WINDOW_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_NEW_RD  = 7'b0000010,
        S_NEW_CAP = 7'b0000100,
        S_SRCH_RD = 7'b0001000,
        S_SRCH_CMP = 7'b0010000,
        S_OFFS    = 7'b0100000,
        S_LIMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic [FW-1:0] k_reg, k_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [STAMP_W-1:0] bound_reg, bound_next;
    logic [TOTAL_W-1:0] sum_reg, sum_next;
    logic [NUM_STAGES-1:0][LAT_W-1:0] newest_reg, newest_next;
    logic [NUM_STAGES-1:0] mask_reg, mask_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [OFS_IDX_W-1:0] oi_reg, oi_next;
    logic done_reg, done_next;

    // shared adder and comparator
    logic [TOTAL_W-1:0] add_b;
    logic [TOTAL_W-1:0] add_sum;
    logic [STAMP_W-1:0] cmp_a, cmp_b;
    logic cmp_lt;

    logic [PW-1:0] top_pos;
    logic [PW-1:0] top_pos_nxt;
    logic [STAGE_W-1:0] stage_inc;

    assign add_sum = sum_reg + add_b;
    assign cmp_lt = cmp_a < cmp_b;
    assign stage_inc = stage_reg + STAGE_W'(1);

    // slot of the newest sample of the current and of the following stage
    always_comb
    begin
        if (wp[stage_reg] == '0)
        begin
            top_pos = PW'(WINDOW_DEPTH - 1);
        end
        else
        begin
            top_pos = wp[stage_reg] - PW'(1);
        end
        if (wp[stage_inc] == '0)
        begin
            top_pos_nxt = PW'(WINDOW_DEPTH - 1);
        end
        else
        begin
            top_pos_nxt = wp[stage_inc] - PW'(1);
        end
    end

    // first entry of a stage search reads the newest slot directly
    always_comb
    begin
        if ((state_reg == S_NEW_RD) || ((state_reg == S_SRCH_RD) && (k_reg == '0)))
        begin
            rd_addr = AW'(stage_reg) * AW'(WINDOW_DEPTH) + AW'(top_pos);
        end
        else
        begin
            rd_addr = AW'(stage_reg) * AW'(WINDOW_DEPTH) + AW'(pos_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        k_next = k_reg;
        pos_next = pos_reg;
        bound_next = bound_reg;
        sum_next = sum_reg;
        newest_next = newest_reg;
        mask_next = mask_reg;
        status_next = status_reg;
        oi_next = oi_reg;
        done_next = done_reg;
        add_b = '0;
        cmp_a = rd_entry.stamp;
        cmp_b = bound_reg;

        if (done_reg && res_ready)
        begin
            done_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    stage_next = '0;
                    mask_next = '0;
                    state_next = S_NEW_RD;
                end
            end
            S_NEW_RD:
            begin
                state_next = S_NEW_CAP;
            end
            S_NEW_CAP:
            begin
                if (fill[stage_reg] == '0)
                begin
                    mask_next[stage_reg] = 1'b1;
                    newest_next[stage_reg] = '0;
                end
                else
                begin
                    newest_next[stage_reg] = rd_entry.value;
                end
                if (stage_reg == '0)
                begin
                    bound_next = rd_entry.stamp;
                    sum_next = TOTAL_W'(rd_entry.value);
                end
                if (stage_reg == STAGE_W'(NUM_STAGES - 1))
                begin
                    if (mask_next != '0)
                    begin
                        sum_next = '0;
                        status_next = STATUS_MISSING;
                        done_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        stage_next = STAGE_W'(1);
                        k_next = '0;
                        state_next = S_SRCH_RD;
                    end
                end
                else
                begin
                    stage_next = stage_inc;
                    state_next = S_NEW_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (k_reg == '0)
                begin
                    pos_next = top_pos;
                end
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (cmp_lt || (k_reg + FW'(1) == fill[stage_reg]))
                begin
                    if (cmp_lt)
                    begin
                        add_b = TOTAL_W'(rd_entry.value);
                        sum_next = add_sum;
                        bound_next = rd_entry.stamp;
                    end
                    else
                    begin
                        bound_next = '0;
                    end
                    k_next = '0;
                    if (stage_reg == STAGE_W'(NUM_STAGES - 1))
                    begin
                        oi_next = '0;
                        state_next = S_OFFS;
                    end
                    else
                    begin
                        stage_next = stage_inc;
                        pos_next = top_pos_nxt;
                        state_next = S_SRCH_RD;
                    end
                end
                else
                begin
                    k_next = k_reg + FW'(1);
                    if (pos_reg == '0)
                    begin
                        pos_next = PW'(WINDOW_DEPTH - 1);
                    end
                    else
                    begin
                        pos_next = pos_reg - PW'(1);
                    end
                    state_next = S_SRCH_RD;
                end
            end
            S_OFFS:
            begin
                add_b = TOTAL_W'(cfg.offsets[oi_reg]);
                sum_next = add_sum;
                oi_next = oi_reg + OFS_IDX_W'(1);
                if (oi_reg == OFS_IDX_W'(NUM_OFFSETS - 1))
                begin
                    state_next = S_LIMIT;
                end
            end
            S_LIMIT:
            begin
                cmp_a = STAMP_W'(cfg.limit);
                cmp_b = STAMP_W'(sum_reg);
                status_next = cmp_lt ? STATUS_OVER : STATUS_OK;
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stage_reg <= '0;
            k_reg <= '0;
            oi_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            k_reg <= k_next;
            oi_reg <= oi_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        bound_reg <= bound_next;
        sum_reg <= sum_next;
        newest_reg <= newest_next;
        mask_reg <= mask_next;
        status_reg <= status_next;
    end

    // a finished result must be handed over before the next word is taken
    assign idle = (state_reg == S_IDLE) && !done_reg;
    assign res_valid = done_reg;
    assign result.newest = newest_reg;
    assign result.missing_mask = mask_reg;
    assign result.status = status_reg;
    assign result.total = sum_reg;

endmodule

// File: rtl/core/chained_stage_latency_monitor.sv
// top level: stream ports, configuration registers, output register
//
// Sample words (tuser 0 to 3) are written to the sample memory as they are taken, so a run
// of samples streams at one word per clock while the sequencer is idle. An evaluation tick
// (tuser 4) holds the input for a sequence that shares one read port of the sample memory,
// one adder and one comparator: it reads the newest entry of each stage, then reads and
// compares each entry examined in the chained search of planning, prediction and tracking
// (at most 3 * WINDOW_DEPTH entries), adds the five layer offsets and compares with the
// limit; a tick that finds an empty window finishes once the newest entries are read.
// The result sits in an output register, so sample words are taken while it waits;
// the next tick is taken once the earlier result has moved to that register.
// Request codes 5 to 7 are accepted and dropped. The memory needs no clearing pass.
module chained_stage_latency_monitor
    import clsm_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [87:0]           s_tdata,   // stamp_ns, latency_us
    input  logic [REQ_W-1:0]      s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // total_us, status, missing_mask, newest_control_us, newest_planning_us,
    // newest_prediction_us, newest_tracking_us
    output logic [135:0]          m_tdata,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [TOTAL_W-1:0]    cfg_wdata
);

    localparam int PW = ptr_w(WINDOW_DEPTH);
    localparam int FW = cnt_w(WINDOW_DEPTH);
    localparam int AW = addr_w(WINDOW_DEPTH);

    cfg_t cfg_reg, cfg_next;
    logic m_tvalid_reg, m_tvalid_next;
    result_t out_reg, out_next;

    logic in_accept;
    logic seq_idle;
    logic start;
    wr_req_t wr;
    logic [AW-1:0] rd_addr;
    entry_t rd_entry;
    logic [NUM_STAGES-1:0][PW-1:0] wp;
    logic [NUM_STAGES-1:0][FW-1:0] fill;
    logic res_ready;
    logic res_valid;
    result_t result;

    assign s_tready = seq_idle;
    assign in_accept = s_tvalid && s_tready;
    assign start = in_accept && (s_tuser == REQ_TICK);

    assign wr.en = in_accept && (s_tuser < REQ_TICK);
    assign wr.stage = s_tuser[STAGE_W-1:0];
    assign wr.entry.stamp = s_tdata[STAMP_W-1:0];
    assign wr.entry.value = s_tdata[STAMP_W+LAT_W-1:STAMP_W];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (cfg_addr)
                CFG_WINDOW_LENGTH:     cfg_next.window_length = cfg_wdata[WLEN_W-1:0];
                CFG_LATENCY_LIMIT:     cfg_next.limit = cfg_wdata;
                CFG_SENSOR_OFFSET:     cfg_next.offsets[0] = cfg_wdata[LAT_W-1:0];
                CFG_PERCEPTION_OFFSET: cfg_next.offsets[1] = cfg_wdata[LAT_W-1:0];
                CFG_PLANNING_OFFSET:   cfg_next.offsets[2] = cfg_wdata[LAT_W-1:0];
                CFG_CONTROL_OFFSET:    cfg_next.offsets[3] = cfg_wdata[LAT_W-1:0];
                CFG_VEHICLE_OFFSET:    cfg_next.offsets[4] = cfg_wdata[LAT_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_next = out_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            out_next = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length <= RST_WINDOW_LENGTH;
            cfg_reg.limit <= RST_LATENCY_LIMIT;
            cfg_reg.offsets <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {6'd0,
                      out_reg.newest[3],
                      out_reg.newest[2],
                      out_reg.newest[1],
                      out_reg.newest[0],
                      out_reg.missing_mask,
                      out_reg.status,
                      out_reg.total};

    clsm_store #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr            (wr),
        .window_length (cfg_reg.window_length),
        .rd_addr       (rd_addr),
        .rd_entry      (rd_entry),
        .wp            (wp),
        .fill          (fill)
    );

    clsm_seq #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .idle      (seq_idle),
        .wp        (wp),
        .fill      (fill),
        .rd_addr   (rd_addr),
        .rd_entry  (rd_entry),
        .cfg       (cfg_reg),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .result    (result)
    );

endmodule
